// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define OAHT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked on every edge including reset.
`define OAHT_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/oaht_pkg.sv -----
// Package of the hash table engine: slot entry layout, command and register codes,
// FNV-1 constants and the controller state type. No dependencies.
package oaht_pkg;

  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int LEN_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int PCT_W       = 7;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_PUT = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_WM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_WM  = 2'd1;

  localparam logic [PCT_W-1:0] HIGH_WM_RESET = 7'd70;
  localparam logic [PCT_W-1:0] LOW_WM_RESET  = 7'd50;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  // prime = 2^40 + 0x1b3
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam int          FNV_PRIME_SH = 40;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic [LEN_W-1:0]   len;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PRB_RD,
    S_PRB_CHK,
    S_UPDATE,
    S_FIN,
    S_RB_CLR,
    S_RB_RD,
    S_RB_CHK,
    S_RB_HASH,
    S_RB_PRB_RD,
    S_RB_PRB_CHK
  } state_t;

endpackage

// ----- hdl/oaht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/oaht_hash.sv -----
// 64-bit FNV-1 hash unit, one key byte per cycle, low byte first.
// Depends on oaht_pkg.
module oaht_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [oaht_pkg::KEY_W-1:0]  key_in,
  input  logic [oaht_pkg::LEN_W-1:0]  len_in,
  output logic                        done,
  output logic [63:0]                 hash
);

  logic                       busy_r;
  logic [oaht_pkg::LEN_W-1:0] cnt_r;
  logic [oaht_pkg::LEN_W-1:0] len_r;
  logic [oaht_pkg::KEY_W-1:0] key_r;
  logic [63:0]                h_r;
  logic [63:0]                h_mul;

  // h * (2^40 + 0x1b3)
  assign h_mul = (h_r << oaht_pkg::FNV_PRIME_SH) + (h_r * oaht_pkg::FNV_PRIME_LO);
  assign done  = busy_r && (cnt_r == len_r);
  assign hash  = h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      len_r  <= len_in;
      key_r  <= key_in;
      h_r    <= oaht_pkg::FNV_BASIS;
    end else if (busy_r) begin
      if (cnt_r == len_r) begin
        busy_r <= 1'b0;
      end else begin
        h_r   <= h_mul ^ {56'd0, key_r[7:0]};
        key_r <= key_r >> 8;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/open_addressing_hash_table.sv -----
// Key-value table with linear probing over an FNV-1 hash, held in one RAM of
// 2*CAPACITY slots (two banks). After reset a clearing pass empties the RAM;
// no item is taken during it. A command is taken in S_IDLE and its key hashed
// byte by byte; each probed slot is read and then checked (one RAM read port,
// registered read data; no probe for an unknown command); then the slot is
// updated and the result loaded into the result register once it is free,
// which shows it the cycle after. The next item is taken only after that load.
// A put that finds the occupied share at or above the high watermark first
// rebuilds into the spare bank: it clears that bank, then reads each source
// slot and, for a live entry, rehashes it and probes the spare bank for an
// empty slot. Rebuild drops tombstones; the table never grows.
// Depends on oaht_pkg, oaht_ram and oaht_hash.
module open_addressing_hash_table #(
  parameter int CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: key_bytes[63:0], key_len[67:64], put_value[99:68], zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [oaht_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: command[1:0]
  input  logic [1:0]                           in_tuser,
  // out_tdata: found[0], read_value[32:1], status[33], zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [oaht_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [oaht_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [oaht_pkg::PCT_W-1:0]           cfg_data
);

  localparam int AW = $clog2(CAPACITY);   // slot index width
  localparam int CW = AW + 1;             // counts up to CAPACITY
  localparam int PW = CW + 8;             // percent product width
  localparam logic [CW-1:0] LAST = CW'(CAPACITY - 1);

  oaht_pkg::state_t state_r, state_nxt;

  // command registers
  logic [1:0]                     cmd_r;
  logic [oaht_pkg::KEY_W-1:0]     key_r;
  logic [oaht_pkg::LEN_W-1:0]     len_r;
  logic [oaht_pkg::VALUE_W-1:0]   val_r;
  logic [AW-1:0]                  hcmd_r;
  logic                           rebuilt_r;

  // table bookkeeping
  logic                           bank_r;
  logic [CW-1:0]                  occ_r;
  logic [CW-1:0]                  live_r;
  logic [CW-1:0]                  moved_r;
  logic [oaht_pkg::PCT_W-1:0]     hw_r;
  logic [oaht_pkg::PCT_W-1:0]     lw_r;

  // probe walk
  logic [CW-1:0]                  i_r;
  logic [CW-1:0]                  rb_r;
  logic [AW:0]                    addr_r;
  logic [AW:0]                    clr_r;
  logic [AW-1:0]                  dh_r;
  logic                           hit_r;
  logic [AW:0]                    hitaddr_r;
  logic                           free_v_r;
  logic                           free_empty_r;
  logic [AW:0]                    freeaddr_r;
  oaht_pkg::entry_t               ent_r;

  // result
  logic                           res_found_r;
  logic [oaht_pkg::VALUE_W-1:0]   res_val_r;
  logic                           res_status_r;
  logic                           out_valid_r;
  logic [oaht_pkg::OUT_TDATA_W-1:0] out_data_r;

  // RAM port
  logic                           ram_we;
  logic [AW:0]                    ram_waddr;
  oaht_pkg::entry_t               ram_wdata;
  logic [AW:0]                    ram_raddr;
  logic [oaht_pkg::ENTRY_W-1:0]   ram_rdata;
  oaht_pkg::entry_t               e;

  // hash unit
  logic                           hash_start;
  logic [oaht_pkg::KEY_W-1:0]     hash_key;
  logic [oaht_pkg::LEN_W-1:0]     hash_len;
  logic                           hash_done;
  logic [63:0]                    hash_val;

  // input decode
  logic [oaht_pkg::LEN_W-1:0]     in_len;
  logic [oaht_pkg::KEY_W-1:0]     in_key;

  logic                           match;
  logic                           e_empty;
  logic                           rb_need;
  logic                           refuse;
  logic                           upd_new;
  logic [PW-1:0]                  occ_prod;
  logic [PW-1:0]                  live_prod;
  logic [CW-1:0]                  moved_now;
  logic                           rb_finish;

  assign e       = oaht_pkg::entry_t'(ram_rdata);
  assign e_empty = (e.tag == oaht_pkg::TAG_EMPTY);
  assign match   = (e.tag == oaht_pkg::TAG_LIVE) && (e.len == len_r) && (e.key == key_r);

  // long keys clamp to KEY_BYTES; bytes past the length are cleared
  assign in_len = (in_tdata[67:64] > oaht_pkg::LEN_W'(oaht_pkg::KEY_BYTES)) ?
                  oaht_pkg::LEN_W'(oaht_pkg::KEY_BYTES) : in_tdata[67:64];
  always_comb begin
    for (int b = 0; b < oaht_pkg::KEY_BYTES; b++) begin
      in_key[8*b +: 8] = (oaht_pkg::LEN_W'(b) < in_len) ? in_tdata[8*b +: 8] : 8'd0;
    end
  end

  // percentages: count * 100 / CAPACITY, CAPACITY a power of two
  assign occ_prod  = PW'(occ_r) * PW'(100);
  assign live_prod = PW'(live_r) * PW'(100);
  assign rb_need   = (occ_prod >> AW) >= PW'(hw_r);
  assign refuse    = !hit_r && (!free_v_r || (rebuilt_r && ((live_prod >> AW) >= PW'(lw_r))));
  assign upd_new   = (cmd_r == oaht_pkg::CMD_PUT) && !hit_r && !refuse;

  assign moved_now = moved_r + CW'(state_r == oaht_pkg::S_RB_PRB_CHK && e_empty);
  assign rb_finish = (rb_r == LAST) &&
                     ((state_r == oaht_pkg::S_RB_CHK && e.tag != oaht_pkg::TAG_LIVE) ||
                      (state_r == oaht_pkg::S_RB_PRB_CHK && (e_empty || i_r == LAST)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oaht_pkg::S_CLEAR:     if (&clr_r) state_nxt = oaht_pkg::S_IDLE;
      oaht_pkg::S_IDLE:      if (in_tvalid) state_nxt = oaht_pkg::S_HASH;
      oaht_pkg::S_HASH: begin
        if (hash_done) begin
          case (cmd_r)
            oaht_pkg::CMD_GET: state_nxt = oaht_pkg::S_PRB_RD;
            oaht_pkg::CMD_DEL: state_nxt = oaht_pkg::S_PRB_RD;
            oaht_pkg::CMD_PUT: state_nxt = rb_need ? oaht_pkg::S_RB_CLR : oaht_pkg::S_PRB_RD;
            default:           state_nxt = oaht_pkg::S_UPDATE;
          endcase
        end
      end
      oaht_pkg::S_PRB_RD:    state_nxt = oaht_pkg::S_PRB_CHK;
      oaht_pkg::S_PRB_CHK: begin
        if (match || e_empty || i_r == LAST) state_nxt = oaht_pkg::S_UPDATE;
        else                                  state_nxt = oaht_pkg::S_PRB_RD;
      end
      oaht_pkg::S_UPDATE:    state_nxt = oaht_pkg::S_FIN;
      oaht_pkg::S_FIN:       if (!out_valid_r || out_tready) state_nxt = oaht_pkg::S_IDLE;
      oaht_pkg::S_RB_CLR:    if (rb_r == LAST) state_nxt = oaht_pkg::S_RB_RD;
      oaht_pkg::S_RB_RD:     state_nxt = oaht_pkg::S_RB_CHK;
      oaht_pkg::S_RB_CHK: begin
        if (e.tag == oaht_pkg::TAG_LIVE) state_nxt = oaht_pkg::S_RB_HASH;
        else if (rb_finish)              state_nxt = oaht_pkg::S_PRB_RD;
        else                             state_nxt = oaht_pkg::S_RB_RD;
      end
      oaht_pkg::S_RB_HASH:   if (hash_done) state_nxt = oaht_pkg::S_RB_PRB_RD;
      oaht_pkg::S_RB_PRB_RD: state_nxt = oaht_pkg::S_RB_PRB_CHK;
      oaht_pkg::S_RB_PRB_CHK: begin
        if (rb_finish)                     state_nxt = oaht_pkg::S_PRB_RD;
        else if (e_empty || i_r == LAST)   state_nxt = oaht_pkg::S_RB_RD;
        else                               state_nxt = oaht_pkg::S_RB_PRB_RD;
      end
      default:               state_nxt = oaht_pkg::S_CLEAR;
    endcase
  end

  // RAM, hash unit and handshake controls
  always_comb begin
    in_tready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = '0;
    ram_raddr  = '0;
    hash_start = 1'b0;
    hash_key   = e.key;
    hash_len   = e.len;
    case (state_r)
      oaht_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      oaht_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        hash_start = in_tvalid;
        hash_key   = in_key;
        hash_len   = in_len;
      end
      oaht_pkg::S_PRB_RD:    ram_raddr = {bank_r, hcmd_r + i_r[AW-1:0]};
      oaht_pkg::S_UPDATE: begin
        ram_wdata.len   = len_r;
        ram_wdata.key   = key_r;
        ram_wdata.value = val_r;
        if (cmd_r == oaht_pkg::CMD_DEL && hit_r) begin
          ram_we        = 1'b1;
          ram_waddr     = hitaddr_r;
          ram_wdata.tag = oaht_pkg::TAG_TOMB;
        end else if (cmd_r == oaht_pkg::CMD_PUT && hit_r) begin
          ram_we        = 1'b1;
          ram_waddr     = hitaddr_r;
          ram_wdata.tag = oaht_pkg::TAG_LIVE;
        end else if (upd_new) begin
          ram_we        = 1'b1;
          ram_waddr     = freeaddr_r;
          ram_wdata.tag = oaht_pkg::TAG_LIVE;
        end
      end
      oaht_pkg::S_RB_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = {~bank_r, rb_r[AW-1:0]};
      end
      oaht_pkg::S_RB_RD:     ram_raddr = {bank_r, rb_r[AW-1:0]};
      oaht_pkg::S_RB_CHK:    hash_start = (e.tag == oaht_pkg::TAG_LIVE);
      oaht_pkg::S_RB_PRB_RD: ram_raddr = {~bank_r, dh_r + i_r[AW-1:0]};
      oaht_pkg::S_RB_PRB_CHK: begin
        ram_we    = e_empty;
        ram_wdata = ent_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaht_pkg::S_CLEAR;
      clr_r       <= '0;
      bank_r      <= 1'b0;
      occ_r       <= '0;
      live_r      <= '0;
      hw_r        <= oaht_pkg::HIGH_WM_RESET;
      lw_r        <= oaht_pkg::LOW_WM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        if (cfg_index == oaht_pkg::REG_HIGH_WM) hw_r <= cfg_data;
        if (cfg_index == oaht_pkg::REG_LOW_WM)  lw_r <= cfg_data;
      end

      // the result register is reloaded in S_FIN
      if (out_valid_r && out_tready && state_r != oaht_pkg::S_FIN) out_valid_r <= 1'b0;

      case (state_r)
        oaht_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        oaht_pkg::S_IDLE: begin
          if (in_tvalid) begin
            cmd_r     <= in_tuser;
            key_r     <= in_key;
            len_r     <= in_len;
            val_r     <= in_tdata[99:68];
            hit_r     <= 1'b0;
            free_v_r  <= 1'b0;
            rebuilt_r <= 1'b0;
          end
        end
        oaht_pkg::S_HASH: begin
          hcmd_r  <= hash_val[AW-1:0];
          i_r     <= '0;
          rb_r    <= '0;
          moved_r <= '0;
          if (hash_done && cmd_r == oaht_pkg::CMD_PUT && rb_need) rebuilt_r <= 1'b1;
        end
        oaht_pkg::S_PRB_RD: addr_r <= {bank_r, hcmd_r + i_r[AW-1:0]};
        oaht_pkg::S_PRB_CHK: begin
          i_r <= i_r + 1'b1;
          if (match) begin
            hit_r     <= 1'b1;
            hitaddr_r <= addr_r;
            res_val_r <= e.value;
          end else if (!free_v_r && (e_empty || e.tag == oaht_pkg::TAG_TOMB)) begin
            free_v_r     <= 1'b1;
            free_empty_r <= e_empty;
            freeaddr_r   <= addr_r;
          end
        end
        oaht_pkg::S_UPDATE: begin
          res_found_r  <= hit_r && (cmd_r == oaht_pkg::CMD_GET || cmd_r == oaht_pkg::CMD_PUT ||
                                    cmd_r == oaht_pkg::CMD_DEL);
          res_status_r <= (cmd_r == oaht_pkg::CMD_PUT) && refuse;
          if (!(cmd_r == oaht_pkg::CMD_GET && hit_r)) res_val_r <= '0;
          if (cmd_r == oaht_pkg::CMD_DEL && hit_r) live_r <= live_r - 1'b1;
          if (upd_new) begin
            live_r <= live_r + 1'b1;
            if (free_empty_r) occ_r <= occ_r + 1'b1;
          end
        end
        oaht_pkg::S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {(oaht_pkg::OUT_TDATA_W - oaht_pkg::VALUE_W - 2)'(0),
                            res_status_r, res_val_r, res_found_r};
          end
        end
        oaht_pkg::S_RB_CLR: begin
          rb_r <= (rb_r == LAST) ? '0 : rb_r + 1'b1;
        end
        oaht_pkg::S_RB_CHK: begin
          ent_r <= e;
          if (e.tag != oaht_pkg::TAG_LIVE) rb_r <= rb_r + 1'b1;
          if (rb_finish) i_r <= '0;
        end
        oaht_pkg::S_RB_HASH: begin
          dh_r <= hash_val[AW-1:0];
          i_r  <= '0;
        end
        oaht_pkg::S_RB_PRB_RD: addr_r <= {~bank_r, dh_r + i_r[AW-1:0]};
        oaht_pkg::S_RB_PRB_CHK: begin
          moved_r <= moved_now;
          i_r     <= rb_finish ? '0 : i_r + 1'b1;
          if (e_empty || i_r == LAST) rb_r <= rb_r + 1'b1;
        end
        default: ;
      endcase

      // rebuild done: swap banks, counts become the moved entries
      if (rb_finish) begin
        bank_r <= ~bank_r;
        live_r <= moved_now;
        occ_r  <= moved_now;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  oaht_ram #(
    .WIDTH (oaht_pkg::ENTRY_W),
    .DEPTH (2 * CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  oaht_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key_in (hash_key),
    .len_in (hash_len),
    .done   (hash_done),
    .hash   (hash_val)
  );

endmodule

// ----- hdl/oaht_checker.sv -----
// Port-level checker for the hash table engine, bound to the top level.
// Depends on assert_macros.svh and oaht_pkg.
`include "assert_macros.svh"

module oaht_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [oaht_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result item holds
  `OAHT_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result item changed while stalled")
  // a refused put never reports a hit
  `OAHT_ASSERT_RST(a_full_no_hit, clk, rst_n, out_tvalid |-> !(out_tdata[0] && out_tdata[33]), "found and full together")
  // a value is only returned on a hit
  `OAHT_ASSERT_RST(a_val_hit, clk, rst_n, out_tvalid && (out_tdata[32:1] != '0) |-> out_tdata[0], "value without hit")
  // the clearing pass blocks items right after reset
  `OAHT_ASSERT_RST(a_clear_blocks, clk, rst_n, $rose(rst_n) |-> !in_tready, "item taken during clearing pass")

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
